/* rtl/core/bfd_pkg.sv */
// Shared types and constants for the box filter downscaler.
// Used by every module under rtl/core except bfd_ram; depends on nothing.
package bfd_pkg;

	localparam int LANES       = 4;
	localparam int CHAN_W      = 8;
	localparam int LANE_W      = 16;
	localparam int PIX_W       = LANES * CHAN_W;
	localparam int SUM_W       = LANES * LANE_W;
	localparam int FACTOR_W    = 5;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_W    = 13;
	localparam int ROW_W       = 12;
	localparam int SQ_W        = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [FACTOR_W-1:0]    RST_FACTOR = 5'd2;
	localparam logic [WIDTH_REG_W-1:0] RST_WIDTH  = 11'd1024;
	localparam logic [HEIGHT_W-1:0]    RST_HEIGHT = 13'd1024;

	typedef struct packed {
		logic push;
	} q_ctl_t;

endpackage

/* rtl/core/bfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/bfd_fifo.sv */
// Short request queue between the front and back ends.
// Depends on bfd_pkg for the queue control struct.
module bfd_fifo #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bfd_pkg::q_ctl_t       ctl,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  pop,
	output logic                  empty,
	output logic                  full,
	output logic [WIDTH-1:0]      rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] ent_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;
	logic             do_pop;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == (AW+1)'(DEPTH));
	assign do_pop = pop && !empty;
	assign rdata  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (ctl.push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			if (ctl.push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !ctl.push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/bfd_front.sv */
// Front end: accepts pixels, tracks raster and block position, and builds
// one request per pixel (sum address, block flags, pixel). Uses bfd_pkg.
module bfd_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_FACTOR = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bfd_pkg::PIX_W-1:0]         pixel_in,
	input  logic [bfd_pkg::FACTOR_W-1:0]      f,
	input  logic [$clog2(MAX_WIDTH):0]        w,
	input  logic [bfd_pkg::HEIGHT_W-1:0]      h,
	input  logic                              q_full,
	output bfd_pkg::q_ctl_t                   q_ctl,
	output logic [$clog2(MAX_WIDTH)+bfd_pkg::PIX_W+3:0] req
);

	localparam int PW = $clog2(MAX_WIDTH);
	localparam int FW = $clog2(MAX_FACTOR);
	localparam int FCW = bfd_pkg::FACTOR_W;

	logic [PW-1:0]             cp_q;
	logic [FW-1:0]             cib_q;
	logic [FW-1:0]             rib_q;
	logic [bfd_pkg::ROW_W-1:0] rp_q;

	logic          acc_en;
	logic [PW-1:0] idx;
	logic          first;
	logic          emit;
	logic          rd;
	logic          fd;
	logic          row_end;
	logic          frame_end;

	assign in_stall = q_full;
	assign acc_en   = in_valid && !q_full;

	assign idx   = (PW'(cib_q) <= cp_q) ? cp_q - PW'(cib_q) : cp_q;
	assign first = (rib_q == '0) && (cib_q == '0);
	assign emit  = (FCW'(cib_q) == f - 1'b1) && (FCW'(rib_q) == f - 1'b1);
	assign rd    = ((PW+2)'(cp_q) + (PW+2)'(f)) >= (PW+2)'(w);
	assign fd    = rd && (((bfd_pkg::HEIGHT_W+1)'(rp_q) + (bfd_pkg::HEIGHT_W+1)'(f))
		>= (bfd_pkg::HEIGHT_W+1)'(h));
	assign row_end   = ((PW+1)'(cp_q) + 1'b1) >= w;
	assign frame_end = row_end && ((bfd_pkg::HEIGHT_W'(rp_q) + 1'b1) >= h);

	assign q_ctl.push = acc_en;
	assign req = {idx, first, emit, rd, fd, pixel_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q  <= '0;
			cib_q <= '0;
			rib_q <= '0;
			rp_q  <= '0;
		end else if (acc_en) begin
			if (row_end) begin
				cp_q  <= '0;
				cib_q <= '0;
				if (frame_end) begin
					rp_q  <= '0;
					rib_q <= '0;
				end else begin
					rp_q  <= rp_q + 1'b1;
					rib_q <= ((FCW'(rib_q) + 1'b1) >= f) ? '0 : rib_q + 1'b1;
				end
			end else begin
				cp_q  <= cp_q + 1'b1;
				cib_q <= ((FCW'(cib_q) + 1'b1) >= f) ? '0 : cib_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/core/bfd_back.sv */
// Back end: pops requests, does the sum read-modify-write in the column
// sum RAM, divides finished block sums and holds the result. Uses bfd_pkg.
module bfd_back #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [bfd_pkg::FACTOR_W-1:0]        f,
	input  logic                                q_empty,
	input  logic [$clog2(MAX_WIDTH)+bfd_pkg::PIX_W+3:0] req,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bfd_pkg::PIX_W-1:0]           pixel_out,
	output logic                                row_done,
	output logic                                frame_done
);

	localparam int PW = $clog2(MAX_WIDTH);
	localparam int LW = bfd_pkg::LANE_W;
	localparam int CW = bfd_pkg::CHAN_W;
	localparam int NL = bfd_pkg::LANES;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;

	logic [2:0] state_q;

	logic [PW-1:0]             idx_q;
	logic                      first_q;
	logic                      emit_q;
	logic                      rd_q;
	logic                      fd_q;
	logic [bfd_pkg::PIX_W-1:0] pix_q;

	logic [bfd_pkg::SUM_W-1:0] rdata;
	logic [bfd_pkg::SUM_W-1:0] base;
	logic [bfd_pkg::SUM_W-1:0] acc;
	logic                      we;
	logic [bfd_pkg::SQ_W-1:0]  sq;

	logic [LW-1:0] dq_q  [NL];
	logic [CW-1:0] rem_q [NL];
	logic [LW-1:0] dq_nx [NL];
	logic [CW-1:0] rem_nx[NL];
	logic [3:0]    cnt_q;
	logic [bfd_pkg::PIX_W-1:0] avg;

	logic out_valid_q;
	logic out_load;

	assign pop = (state_q == ST_IDLE) && !q_empty;
	assign we  = (state_q == ST_ADD);
	assign sq  = bfd_pkg::SQ_W'(f) * bfd_pkg::SQ_W'(f);

	bfd_ram #(
		.WIDTH(bfd_pkg::SUM_W),
		.DEPTH(MAX_WIDTH)
	) u_sums (
		.clk  (clk),
		.we   (we),
		.waddr(idx_q),
		.wdata(acc),
		.raddr(req[PW+bfd_pkg::PIX_W+3:bfd_pkg::PIX_W+4]),
		.rdata(rdata)
	);

	assign base = first_q ? '0 : rdata;

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			acc[LW*k +: LW] = base[LW*k +: LW] + LW'(pix_q[CW*k +: CW]);
		end
	end

	always_comb begin
		logic [CW:0] r2;
		for (int k = 0; k < NL; k++) begin
			r2 = {rem_q[k], dq_q[k][LW-1]};
			if (r2 >= sq) begin
				rem_nx[k] = CW'(r2 - sq);
				dq_nx[k]  = {dq_q[k][LW-2:0], 1'b1};
			end else begin
				rem_nx[k] = r2[CW-1:0];
				dq_nx[k]  = {dq_q[k][LW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			avg[CW*k +: CW] = (dq_q[k][LW-1:CW] != '0) ? {CW{1'b1}} : dq_q[k][CW-1:0];
		end
	end

	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q   <= req[PW+bfd_pkg::PIX_W+3:bfd_pkg::PIX_W+4];
			first_q <= req[bfd_pkg::PIX_W+3];
			emit_q  <= req[bfd_pkg::PIX_W+2];
			rd_q    <= req[bfd_pkg::PIX_W+1];
			fd_q    <= req[bfd_pkg::PIX_W];
			pix_q   <= req[bfd_pkg::PIX_W-1:0];
		end
		if (state_q == ST_ADD) begin
			for (int k = 0; k < NL; k++) begin
				dq_q[k]  <= acc[LW*k +: LW];
				rem_q[k] <= '0;
			end
		end else if (state_q == ST_DIV) begin
			for (int k = 0; k < NL; k++) begin
				dq_q[k]  <= dq_nx[k];
				rem_q[k] <= rem_nx[k];
			end
		end
		if (out_load) begin
			pixel_out  <= avg;
			row_done   <= rd_q;
			frame_done <= fd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					cnt_q   <= '0;
					state_q <= emit_q ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'hF) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_add_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD) |-> $past(pop))
		else $error("sum update without a popped request");
	a_div_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_OUT) |-> emit_q)
		else $error("divider running for a pixel that closes no block");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("request popped while back end busy");
	a_out_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_OUT) |-> ($past(state_q) == ST_DIV && $past(cnt_q) == 4'hF))
		else $error("result ready before divider finished");
`endif

endmodule

/* rtl/core/box_filter_downscale_core.sv */
// Box filter downscaler top level: config registers, front end, request
// queue and back end. Depends on bfd_pkg, bfd_front, bfd_fifo, bfd_back.
//
// Pixels enter in raster order; each factor-by-factor block yields one
// averaged pixel (per-channel sum divided by factor squared, truncated)
// with row and frame end marks. The front end takes one pixel per cycle
// until its four-entry request queue fills. The back end takes one request
// at a time: it does the column sum RAM read and write-back for each pixel,
// and on a block's last pixel also runs the 16-step divider and the output
// load, which waits while out_stall holds the last result. The sum
// RAM needs no clearing pass after reset. Change registers only while idle.
module box_filter_downscale_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_FACTOR = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [bfd_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [bfd_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [bfd_pkg::PIX_W-1:0]          pixel_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bfd_pkg::PIX_W-1:0]          pixel_out,
	output logic                               row_done,
	output logic                               frame_done
);

	localparam int PW  = $clog2(MAX_WIDTH);
	localparam int RW  = PW + bfd_pkg::PIX_W + 4;
	localparam int WCW = ((PW + 1) > bfd_pkg::WIDTH_REG_W) ? (PW + 2) : (bfd_pkg::WIDTH_REG_W + 1);

	logic [bfd_pkg::FACTOR_W-1:0]    factor_q;
	logic [bfd_pkg::WIDTH_REG_W-1:0] width_q;
	logic [bfd_pkg::HEIGHT_W-1:0]    height_q;

	logic [bfd_pkg::FACTOR_W-1:0] f;
	logic [PW:0]                  w;
	logic [bfd_pkg::HEIGHT_W-1:0] h;

	bfd_pkg::q_ctl_t q_ctl;
	logic [RW-1:0]   req_in;
	logic [RW-1:0]   req_out;
	logic            q_full;
	logic            q_empty;
	logic            pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= bfd_pkg::RST_FACTOR;
			width_q  <= bfd_pkg::RST_WIDTH;
			height_q <= bfd_pkg::RST_HEIGHT;
		end else if (wr_en) begin
			case (wr_index)
				bfd_pkg::REG_FACTOR: factor_q <= wr_data[bfd_pkg::FACTOR_W-1:0];
				bfd_pkg::REG_WIDTH:  width_q  <= wr_data[bfd_pkg::WIDTH_REG_W-1:0];
				bfd_pkg::REG_HEIGHT: height_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (factor_q == '0) begin
			f = bfd_pkg::FACTOR_W'(1);
		end else if (factor_q > bfd_pkg::FACTOR_W'(MAX_FACTOR)) begin
			f = bfd_pkg::FACTOR_W'(MAX_FACTOR);
		end else begin
			f = factor_q;
		end
		if (width_q == '0) begin
			w = (PW+1)'(1);
		end else if (WCW'(width_q) > WCW'(MAX_WIDTH)) begin
			w = (PW+1)'(MAX_WIDTH);
		end else begin
			w = (PW+1)'(width_q);
		end
		if (height_q == '0) begin
			h = bfd_pkg::HEIGHT_W'(1);
		end else if (height_q > bfd_pkg::MAX_HEIGHT) begin
			h = bfd_pkg::MAX_HEIGHT;
		end else begin
			h = height_q;
		end
	end

	bfd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_FACTOR(MAX_FACTOR)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_in(pixel_in),
		.f       (f),
		.w       (w),
		.h       (h),
		.q_full  (q_full),
		.q_ctl   (q_ctl),
		.req     (req_in)
	);

	bfd_fifo #(
		.WIDTH(RW),
		.DEPTH(4)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (q_ctl),
		.wdata (req_in),
		.pop   (pop),
		.empty (q_empty),
		.full  (q_full),
		.rdata (req_out)
	);

	bfd_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.f         (f),
		.q_empty   (q_empty),
		.req       (req_out),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.row_done  (row_done),
		.frame_done(frame_done)
	);

endmodule

/* tb/tb_box_filter_downscale_core.sv */
// Testbench for box_filter_downscale_core: drives raster frames under several
// factor and size settings with random idling and checks every averaged pixel.
// Depends on bfd_pkg and the box_filter_downscale_core RTL.
module tb_box_filter_downscale_core;

	localparam int MAXW = 1024;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [bfd_pkg::PIX_W-1:0] pix;
		logic                      rd;
		logic                      fd;
	} avg_t;

	logic                           clk;
	logic                           arst_n;
	logic                           wr_en;
	logic [bfd_pkg::CFG_IDX_W-1:0]  wr_index;
	logic [bfd_pkg::CFG_DATA_W-1:0] wr_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [bfd_pkg::PIX_W-1:0]      pixel_in;
	logic                           out_valid;
	logic                           out_stall;
	logic [bfd_pkg::PIX_W-1:0]      pixel_out;
	logic                           row_done;
	logic                           frame_done;

	box_filter_downscale_core i_dut (.*);

	avg_t           avg_q[$];
	logic [63:0]    sums[MAXW];
	int unsigned    cur_factor, cur_width, cur_height;
	int unsigned    col_pos, col_blk, row_blk, row_pos;
	int             send_idle, recv_stall;
	int             errors;
	longint         cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// predict the averaged pixel, if any, that one input pixel completes
	task automatic predict_pixel(logic [bfd_pkg::PIX_W-1:0] px);
		int unsigned f, w, h, idx, lane, q;
		logic [63:0] acc;
		avg_t r;
		f = clamp_cfg(cur_factor, 16);
		w = clamp_cfg(cur_width, MAXW);
		h = clamp_cfg(cur_height, 4096);
		idx = (col_blk <= col_pos) ? col_pos - col_blk : col_pos;
		if (idx >= MAXW)
			idx = MAXW - 1;
		acc = (row_blk == 0 && col_blk == 0) ? 64'd0 : sums[idx];
		for (int k = 0; k < bfd_pkg::LANES; k++)
			acc[16*k +: 16] = acc[16*k +: 16] + px[8*k +: 8];
		sums[idx] = acc;
		if (col_blk == f - 1 && row_blk == f - 1) begin
			for (int k = 0; k < bfd_pkg::LANES; k++) begin
				lane = acc[16*k +: 16];
				q = lane / (f * f);
				if (q > 255)
					q = 255;
				r.pix[8*k +: 8] = q[7:0];
			end
			r.rd = (col_pos + f >= w);
			r.fd = r.rd && (row_pos + f >= h);
			avg_q.push_back(r);
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			col_blk = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				row_blk = 0;
			end else begin
				row_pos++;
				row_blk = (row_blk + 1 >= f) ? 0 : row_blk + 1;
			end
		end else begin
			col_pos++;
			col_blk = (col_blk + 1 >= f) ? 0 : col_blk + 1;
		end
	endtask

	task automatic send_pixel(logic [bfd_pkg::PIX_W-1:0] px);
		while (send_idle > 0 && $urandom_range(99, 0) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_pixel(px);
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_stall <= (recv_stall > 0) && ($urandom_range(99, 0) < recv_stall);

	always @(posedge clk) begin
		avg_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (avg_q.size() == 0) begin
				$display("%0t: unexpected pixel %h", $time, pixel_out);
				errors++;
			end else begin
				e = avg_q.pop_front();
				if (e.pix !== pixel_out || e.rd !== row_done || e.fd !== frame_done) begin
					$display("%0t: expected %h rd %b fd %b, got %h rd %b fd %b", $time,
						e.pix, e.rd, e.fd, pixel_out, row_done, frame_done);
					errors++;
				end
			end
		end
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (avg_q.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [bfd_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val[bfd_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		case (idx)
			bfd_pkg::REG_FACTOR: cur_factor = val & 32'h1F;
			bfd_pkg::REG_WIDTH:  cur_width = val & 32'h7FF;
			bfd_pkg::REG_HEIGHT: cur_height = val & 32'h1FFF;
			default: ;
		endcase
	endtask

	task automatic set_frame(int unsigned f, int unsigned w, int unsigned h);
		drain();
		write_reg(bfd_pkg::REG_FACTOR, f);
		write_reg(bfd_pkg::REG_WIDTH, w);
		write_reg(bfd_pkg::REG_HEIGHT, h);
		wr_en <= 1'b0;
	endtask

	function automatic logic [bfd_pkg::PIX_W-1:0] rand_pixel(int mode);
		case (mode)
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_frame(int mode);
		int unsigned n;
		n = clamp_cfg(cur_width, MAXW) * clamp_cfg(cur_height, 4096);
		for (int unsigned i = 0; i < n; i++)
			send_pixel(rand_pixel(mode));
	endtask

	task automatic test_extremes();
		set_frame(2, 4, 2);
		send_frame(1);
		send_frame(0);
		set_frame(1, 3, 2);
		send_frame(2);
	endtask

	task automatic test_ragged_sizes();
		set_frame(3, 5, 4);
		send_frame(2);
		set_frame(0, 0, 0);
		send_frame(1);
	endtask

	task automatic test_max_factor();
		set_frame(31, 17, 17);
		send_frame(1);
	endtask

	// the tall frame stops at row 8; the short frame wraps that row and then
	// runs a full frame, so the raster ends at the origin
	task automatic test_wide_row();
		set_frame(1, 2047, 1);
		send_frame(2);
		set_frame(4, 4, 8191);
		for (int i = 0; i < 32; i++)
			send_pixel($urandom);
		set_frame(4, 4, 8);
		for (int i = 0; i < 36; i++)
			send_pixel($urandom);
	endtask

	task automatic test_random_frames(int unsigned budget);
		int unsigned f, w, h, sent;
		sent = 0;
		while (sent < budget) begin
			f = $urandom_range(4, 1);
			w = f * $urandom_range(4, 1) + $urandom_range(1, 0);
			h = f * $urandom_range(3, 1) + $urandom_range(1, 0);
			set_frame(f, w, h);
			send_frame($urandom_range(9, 0) == 0 ? $urandom_range(1, 0) : 2);
			sent += w * h;
		end
	endtask

	task automatic test_pause_until_empty();
		set_frame(2, 4, 4);
		for (int i = 0; i < 8; i++)
			send_pixel($urandom);
		in_valid <= 1'b0;
		while (avg_q.size() != 0)
			@(negedge clk);
		for (int i = 0; i < 8; i++)
			send_pixel($urandom);
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		send_idle = 0;
		recv_stall = 0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = bfd_pkg::REG_FACTOR;
		wr_data = '0;
		in_valid = 1'b0;
		pixel_in = '0;
		out_stall = 1'b0;
		cur_factor = bfd_pkg::RST_FACTOR;
		cur_width = bfd_pkg::RST_WIDTH;
		cur_height = bfd_pkg::RST_HEIGHT;
		col_pos = 0;
		col_blk = 0;
		row_blk = 0;
		row_pos = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_ragged_sizes();
		test_max_factor();
		test_wide_row();
		test_pause_until_empty();
		test_random_frames(70);
		send_idle = 75;
		test_random_frames(70);
		send_idle = 0;
		recv_stall = 75;
		test_random_frames(70);
		send_idle = 16;
		recv_stall = 16;
		test_random_frames(70);
		send_idle = 0;
		recv_stall = 0;
		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

/* sim.f */
rtl/core/bfd_pkg.sv
rtl/core/bfd_ram.sv
rtl/core/bfd_fifo.sv
rtl/core/bfd_front.sv
rtl/core/bfd_back.sv
rtl/core/box_filter_downscale_core.sv
tb/tb_box_filter_downscale_core.sv
